/* sv/bfa_pkg.sv */
// Shared constants, types and helper functions of the bitmap frame allocator.
package bfa_pkg;

  localparam int WORD_COUNT = 32768;
  localparam int LOW_WORDS  = 8;
  localparam int WORD_BITS  = 32;
  localparam int BIT_IDX_W  = 5;
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int KIND_W     = 2;
  localparam int FRAME_W    = 20;
  localparam int COUNT_W    = 21;
  localparam int STATUS_W   = 3;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_IDX_W-1:0] bit_idx_t;

  localparam count_t TOTAL_FRAMES       = COUNT_W'(WORD_COUNT * WORD_BITS);
  localparam frame_t FIRST_USABLE_FRAME = FRAME_W'(2);
  localparam word_t  FULL_WORD          = '1;

  localparam kind_t KIND_ADD        = 2'd0;
  localparam kind_t KIND_ALLOC_HIGH = 2'd1;
  localparam kind_t KIND_ALLOC_LOW  = 2'd2;
  localparam kind_t KIND_FREE       = 2'd3;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_OOM    = 3'd1;
  localparam status_t ST_LOW    = 3'd2;
  localparam status_t ST_DOUBLE = 3'd3;
  localparam status_t ST_BEYOND = 3'd4;

  // Index of the lowest clear bit; a word with bits 0 to 30 set gives 31.
  function automatic bit_idx_t lowest_clear(input word_t v);
    bit_idx_t b;
    b = BIT_IDX_W'(WORD_BITS - 1);
    for (int i = WORD_BITS - 2; i >= 0; i--) begin
      if (!v[i]) begin
        b = BIT_IDX_W'(i);
      end
    end
    return b;
  endfunction

endpackage

/* sv/bfa_in_if.sv */
// Request channel of the bitmap frame allocator.
interface bfa_in_if;
  logic              valid;
  logic              ready;
  bfa_pkg::kind_t    kind;
  bfa_pkg::frame_t   frame_number;
  bfa_pkg::count_t   frame_count;

  modport source(output valid, kind, frame_number, frame_count, input ready);
  modport sink(input valid, kind, frame_number, frame_count, output ready);
endinterface

/* sv/bfa_out_if.sv */
// Response channel of the bitmap frame allocator.
interface bfa_out_if;
  logic              valid;
  logic              ready;
  bfa_pkg::frame_t   result_frame;
  bfa_pkg::status_t  status;

  modport source(output valid, result_frame, status, input ready);
  modport sink(input valid, result_frame, status, output ready);
endinterface

/* sv/bitmap_frame_allocator.sv */
// Top level of the bitmap frame allocator: sequencer around the frame bitmap RAM.
//
// One request word on req carries kind, frame_number and frame_count; one
// response word on rsp carries result_frame and status for every request.
// Kind 0 adds a usable region, kind 1 and 2 allocate from the high and low
// pool (first fit, lowest frame), kind 3 frees one frame.
// After reset the sequencer sweeps the bitmap RAM, writing every word as all
// reserved, and req.ready stays low until the sweep is done.
// The block handles one request at a time; req.ready is high only while idle.
// Path from acceptance to the response: a refused free or an add that clears
// nothing goes straight to the response step; a free reads its word, then
// clears the bit; an allocation reads bitmap words up to the hit or the pool's
// end; an add writes fully covered words and reads, then writes edge words.
// The next request can be taken as soon as rsp.valid rises.
// The pace is set by the single RAM port pair: one word read or written a cycle.
// The response sits in an output register; the next request is accepted while
// it waits. A stalled receiver holds the response and the following one waits
// in the sequencer until the register frees.
module bitmap_frame_allocator (
  input  logic      clk,
  input  logic      rst,
  bfa_in_if.sink    req,
  bfa_out_if.source rsp
);
  import bfa_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_ADD_WR = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_FREE   = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  localparam addr_t LAST_ADDR = ADDR_W'(WORD_COUNT - 1);

  logic [2:0] state, state_next;
  addr_t      clr_addr, clr_addr_next;
  count_t     hi_end, hi_end_next;
  frame_t     rng_lo, rng_lo_next;
  frame_t     rng_last, rng_last_next;
  addr_t      cur_addr, cur_addr_next;
  addr_t      scan_addr, scan_addr_next;
  addr_t      scan_last, scan_last_next;
  logic       scan_more, scan_more_next;
  logic       chk_valid, chk_valid_next;
  addr_t      chk_addr, chk_addr_next;
  frame_t     res_frame, res_frame_next;
  status_t    res_status, res_status_next;
  logic       out_valid, out_valid_next;
  frame_t     out_frame, out_frame_next;
  status_t    out_status, out_status_next;

  logic   wr_en, rd_en;
  addr_t  wr_addr, rd_addr;
  word_t  wr_data, rd_data;

  logic [COUNT_W:0] add_sum;
  count_t   add_end;
  frame_t   add_lo;
  bit_idx_t lb, ub, hit_bit;
  word_t    add_mask;
  logic     last_word;

  bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_bits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.result_frame = out_frame;
  assign rsp.status       = out_status;

  // Region end saturates at the bitmap size; frames 0 and 1 never get freed.
  // The sum carries one extra bit so that a large count cannot wrap.
  assign add_sum = (COUNT_W+1)'(req.frame_number) + (COUNT_W+1)'(req.frame_count);
  assign add_end = (add_sum > (COUNT_W+1)'(TOTAL_FRAMES)) ? TOTAL_FRAMES
                                                           : COUNT_W'(add_sum);
  assign add_lo  = (req.frame_number < FIRST_USABLE_FRAME) ? FIRST_USABLE_FRAME
                                                           : req.frame_number;

  // Mask of the region's bits inside the current word.
  assign lb        = (cur_addr == rng_lo[ADDR_W+4:5]) ? rng_lo[4:0] : '0;
  assign ub        = (cur_addr == rng_last[ADDR_W+4:5]) ? rng_last[4:0] : '1;
  assign add_mask  = (FULL_WORD << lb) & (FULL_WORD >> (BIT_IDX_W'(WORD_BITS - 1) - ub));
  assign last_word = (cur_addr == rng_last[ADDR_W+4:5]);
  assign hit_bit   = lowest_clear(rd_data);

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    hi_end_next     = hi_end;
    rng_lo_next     = rng_lo;
    rng_last_next   = rng_last;
    cur_addr_next   = cur_addr;
    scan_addr_next  = scan_addr;
    scan_last_next  = scan_last;
    scan_more_next  = scan_more;
    chk_valid_next  = chk_valid;
    chk_addr_next   = chk_addr;
    res_frame_next  = res_frame;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_frame_next  = out_frame;
    out_status_next = out_status;
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = cur_addr;

    if (rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = FULL_WORD;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // The free path reads its word already in the accepting cycle.
        rd_en   = req.valid && (req.kind == KIND_FREE);
        rd_addr = req.frame_number[ADDR_W+4:5];
        if (req.valid) begin
          res_frame_next  = '0;
          res_status_next = ST_OK;
          state_next      = S_RESP;
          case (req.kind)
            KIND_ADD: begin
              if (req.frame_count != '0) begin
                if (add_end > hi_end) begin
                  hi_end_next = add_end;
                end
                if (COUNT_W'(add_lo) < add_end) begin
                  rng_lo_next   = add_lo;
                  rng_last_next = FRAME_W'(add_end - COUNT_W'(1));
                  cur_addr_next = add_lo[ADDR_W+4:5];
                  state_next    = S_ADD;
                end
              end
            end
            KIND_ALLOC_HIGH, KIND_ALLOC_LOW: begin
              scan_addr_next = (req.kind == KIND_ALLOC_HIGH) ? ADDR_W'(LOW_WORDS) : '0;
              scan_last_next = (req.kind == KIND_ALLOC_HIGH) ? LAST_ADDR
                                                             : ADDR_W'(LOW_WORDS - 1);
              scan_more_next = 1'b1;
              chk_valid_next = 1'b0;
              state_next     = S_SCAN;
            end
            default: begin
              if (req.frame_number < FIRST_USABLE_FRAME) begin
                res_status_next = ST_LOW;
              end else if (COUNT_W'(req.frame_number) >= hi_end ||
                           COUNT_W'(req.frame_number) >= TOTAL_FRAMES) begin
                res_status_next = ST_BEYOND;
              end else begin
                rng_lo_next = req.frame_number;
                state_next  = S_FREE;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        if (add_mask == FULL_WORD) begin
          // A fully covered word needs no read.
          wr_en   = 1'b1;
          wr_addr = cur_addr;
          wr_data = '0;
          cur_addr_next = cur_addr + ADDR_W'(1);
          if (last_word) begin
            state_next = S_RESP;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = cur_addr;
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur_addr;
        wr_data = rd_data & ~add_mask;
        cur_addr_next = cur_addr + ADDR_W'(1);
        state_next    = last_word ? S_RESP : S_ADD;
      end
      S_SCAN: begin
        // Reads run one word ahead of the check of the word that came back.
        if (chk_valid && (rd_data != FULL_WORD)) begin
          wr_en   = 1'b1;
          wr_addr = chk_addr;
          wr_data = rd_data | (WORD_BITS'(1) << hit_bit);
          res_frame_next  = FRAME_W'({chk_addr, hit_bit});
          res_status_next = ST_OK;
          state_next      = S_RESP;
        end else if (!chk_valid && !scan_more) begin
          res_frame_next  = '0;
          res_status_next = ST_OOM;
          state_next      = S_RESP;
        end else begin
          chk_valid_next = scan_more;
          if (scan_more) begin
            rd_en          = 1'b1;
            rd_addr        = scan_addr;
            chk_addr_next  = scan_addr;
            scan_addr_next = scan_addr + ADDR_W'(1);
            if (scan_addr == scan_last) begin
              scan_more_next = 1'b0;
            end
          end
        end
      end
      S_FREE: begin
        if (!rd_data[rng_lo[4:0]]) begin
          res_status_next = ST_DOUBLE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = rng_lo[ADDR_W+4:5];
          wr_data = rd_data & ~(WORD_BITS'(1) << rng_lo[4:0]);
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_frame_next  = res_frame;
          out_status_next = res_status;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      hi_end    <= '0;
      scan_more <= 1'b0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      hi_end    <= hi_end_next;
      scan_more <= scan_more_next;
      chk_valid <= chk_valid_next;
      out_valid <= out_valid_next;
    end
    rng_lo     <= rng_lo_next;
    rng_last   <= rng_last_next;
    cur_addr   <= cur_addr_next;
    scan_addr  <= scan_addr_next;
    scan_last  <= scan_last_next;
    chk_addr   <= chk_addr_next;
    res_frame  <= res_frame_next;
    res_status <= res_status_next;
    out_frame  <= out_frame_next;
    out_status <= out_status_next;
  end

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while a previous one is in progress");

  a_resp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == S_RESP))
    else $error("response word appeared without the response step");

  a_alloc_one_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_valid && rd_data != FULL_WORD) |->
      (wr_en && wr_addr == chk_addr && $countones(wr_data ^ rd_data) == 1))
    else $error("allocation did not set exactly one frame bit");

  a_end_bound: assert property (@(posedge clk) disable iff (rst)
    hi_end <= TOTAL_FRAMES)
    else $error("highest end frame beyond the bitmap");
`endif

endmodule

/* sv/bfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
